// File: src/imb_pkg.sv
// ----------------------------------------------------------------------------
// Inter-core mailbox package
// Shared constants, codes and the command and status structs between the
// mailbox controller and datapath.
// ----------------------------------------------------------------------------
package imb_pkg;

  localparam int CORES       = 4;
  localparam int PAYLOAD_MAX = 64;

  localparam int BUFS      = CORES + 1;
  localparam int SLOT_W    = (CORES > 1) ? $clog2(CORES) : 1;
  localparam int PTR_W     = $clog2(BUFS);
  localparam int IDX_W     = (PAYLOAD_MAX > 1) ? $clog2(PAYLOAD_MAX) : 1;
  localparam int MEM_DEPTH = BUFS * PAYLOAD_MAX;
  localparam int ADDR_W    = $clog2(MEM_DEPTH);

  localparam int OP_W     = 2;
  localparam int HUB_W    = 2;
  localparam int REQ_W    = 2;
  localparam int CORE_W   = 3;
  localparam int TID_W    = 16;
  localparam int BYTE_W   = 8;
  localparam int LEN_W    = 7;
  localparam int STATUS_W = 3;
  localparam int NOTIFY_W = 2;

  typedef enum logic [OP_W-1:0] {
    OP_SEND,
    OP_FWD,
    OP_RECV,
    OP_RSVD
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK,
    ST_BUSY,
    ST_INVALID,
    ST_SELF,
    ST_NOT_HUB
  } status_t;

  typedef struct packed {
    logic    stage;
    logic    post;
    logic    recv_open;
    logic    recv_step;
    logic    reply;
    status_t reply_code;
  } imb_cmd_t;

  typedef struct packed {
    logic    recv_ready;
    status_t recv_code;
    logic    recv_final;
  } imb_stat_t;

  function automatic logic [ADDR_W-1:0] buf_addr(input logic [PTR_W-1:0] ptr,
                                                 input logic [IDX_W-1:0] idx);
    buf_addr = ADDR_W'(ptr) * ADDR_W'(PAYLOAD_MAX) + ADDR_W'(idx);
  endfunction

endpackage

// File: src/imb_ctrl.sv
// ----------------------------------------------------------------------------
// Inter-core mailbox controller
// Accepts items, sequences receive streams and issues datapath commands.
// ----------------------------------------------------------------------------
module imb_ctrl (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [imb_pkg::OP_W-1:0]    op,
  input  logic                        byte_last,
  input  imb_pkg::imb_stat_t          stat,
  output logic                        busy,
  output imb_pkg::imb_cmd_t           cmd
);

  typedef enum logic {
    S_IDLE,
    S_RECV
  } state_t;

  state_t state;
  state_t state_next;
  logic   accept;

  assign busy   = rst | (state == S_RECV);
  assign accept = start & ~busy;

  always_comb begin
    cmd            = '0;
    cmd.reply_code = imb_pkg::ST_OK;
    state_next     = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          unique case (imb_pkg::op_t'(op)) inside
            imb_pkg::OP_SEND, imb_pkg::OP_FWD: begin
              cmd.stage = 1'b1;
              cmd.post  = byte_last;
            end
            imb_pkg::OP_RECV: begin
              if (stat.recv_ready) begin
                cmd.recv_open = 1'b1;
                state_next    = S_RECV;
              end else begin
                cmd.reply      = 1'b1;
                cmd.reply_code = stat.recv_code;
              end
            end
            default: begin
              cmd.reply      = 1'b1;
              cmd.reply_code = imb_pkg::ST_INVALID;
            end
          endcase
        end
      end
      S_RECV: begin
        cmd.recv_step = 1'b1;
        if (stat.recv_final) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// File: src/imb_dp.sv
// ----------------------------------------------------------------------------
// Inter-core mailbox datapath
// Staging buffer, slot headers, pointer-swapped payload buffers and the
// registered result ports.
// ----------------------------------------------------------------------------
module imb_dp (
  input  logic                            clk,
  input  logic                            rst,
  input  imb_pkg::imb_cmd_t               cmd,
  input  logic [imb_pkg::OP_W-1:0]        op,
  input  logic [imb_pkg::REQ_W-1:0]       requester_core,
  input  logic [imb_pkg::CORE_W-1:0]      target_core,
  input  logic [imb_pkg::CORE_W-1:0]      end_core,
  input  logic [imb_pkg::TID_W-1:0]       dst_thread,
  input  logic [imb_pkg::CORE_W-1:0]      origin_core,
  input  logic [imb_pkg::TID_W-1:0]       src_tid,
  input  logic [imb_pkg::BYTE_W-1:0]      data_byte,
  input  logic                            cfg_valid,
  input  logic [imb_pkg::HUB_W-1:0]       cfg_data,
  output imb_pkg::imb_stat_t              stat,
  output logic                            strobe,
  output logic [imb_pkg::STATUS_W-1:0]    status,
  output logic [imb_pkg::LEN_W-1:0]       length,
  output logic [imb_pkg::CORE_W-1:0]      out_src_core,
  output logic [imb_pkg::TID_W-1:0]       out_src_tid,
  output logic [imb_pkg::CORE_W-1:0]      out_final_dest_core,
  output logic [imb_pkg::TID_W-1:0]       out_dest_tid,
  output logic [imb_pkg::BYTE_W-1:0]      out_byte,
  output logic                            last,
  output logic                            notify_valid,
  output logic [imb_pkg::NOTIFY_W-1:0]    notify_core
);

  logic [imb_pkg::HUB_W-1:0]   hub_core;
  logic                        slot_full       [imb_pkg::CORES];
  logic [imb_pkg::CORE_W-1:0]  slot_src_core   [imb_pkg::CORES];
  logic [imb_pkg::TID_W-1:0]   slot_src_tid    [imb_pkg::CORES];
  logic [imb_pkg::CORE_W-1:0]  slot_final_dest [imb_pkg::CORES];
  logic [imb_pkg::TID_W-1:0]   slot_dest_tid   [imb_pkg::CORES];
  logic [imb_pkg::LEN_W-1:0]   slot_length     [imb_pkg::CORES];
  logic [imb_pkg::PTR_W-1:0]   buf_ptr         [imb_pkg::CORES];
  logic [imb_pkg::PTR_W-1:0]   stg_ptr;
  logic [imb_pkg::LEN_W-1:0]   stg_count;
  logic                        stg_overflow;
  logic [imb_pkg::SLOT_W-1:0]  rx_slot;
  logic [imb_pkg::IDX_W-1:0]   rx_idx;
  logic [imb_pkg::LEN_W-1:0]   rx_len;
  logic [imb_pkg::BYTE_W-1:0]  mem [imb_pkg::MEM_DEPTH];

  logic                        route_ok;
  logic                        req_ok;
  logic [imb_pkg::SLOT_W-1:0]  route_slot;
  logic [imb_pkg::SLOT_W-1:0]  req_slot;
  logic                        stg_room;
  logic [imb_pkg::LEN_W-1:0]   post_len;
  logic                        post_ovf;
  logic                        is_fwd;
  logic [imb_pkg::CORE_W-1:0]  post_src;
  logic [imb_pkg::CORE_W-1:0]  post_fdest;
  imb_pkg::status_t            post_status;
  logic                        commit;
  logic [imb_pkg::ADDR_W-1:0]  wr_addr;
  logic [imb_pkg::ADDR_W-1:0]  rd_addr;

  assign route_ok   = 32'(target_core) < imb_pkg::CORES;
  assign req_ok     = 32'(requester_core) < imb_pkg::CORES;
  assign route_slot = imb_pkg::SLOT_W'(target_core);
  assign req_slot   = imb_pkg::SLOT_W'(requester_core);
  assign stg_room   = 32'(stg_count) < imb_pkg::PAYLOAD_MAX;
  assign post_len   = stg_room ? stg_count + imb_pkg::LEN_W'(1) : stg_count;
  assign post_ovf   = stg_overflow | ~stg_room;
  assign is_fwd     = imb_pkg::op_t'(op) == imb_pkg::OP_FWD;
  assign post_src   = is_fwd ? origin_core : imb_pkg::CORE_W'(requester_core);
  assign post_fdest = is_fwd ? target_core : end_core;

  always_comb begin
    if (is_fwd && (requester_core != hub_core)) begin
      post_status = imb_pkg::ST_NOT_HUB;
    end else if (!route_ok || post_ovf || (post_len == '0)) begin
      post_status = imb_pkg::ST_INVALID;
    end else if (target_core == post_src) begin
      post_status = imb_pkg::ST_SELF;
    end else if (slot_full[route_slot]) begin
      post_status = imb_pkg::ST_BUSY;
    end else begin
      post_status = imb_pkg::ST_OK;
    end
  end

  assign commit  = cmd.post && (post_status == imb_pkg::ST_OK);
  assign wr_addr = imb_pkg::buf_addr(stg_ptr, stg_count[imb_pkg::IDX_W-1:0]);
  assign rd_addr = imb_pkg::buf_addr(buf_ptr[rx_slot], rx_idx);

  assign stat.recv_ready = req_ok && slot_full[req_slot];
  assign stat.recv_code  = req_ok ? imb_pkg::ST_BUSY : imb_pkg::ST_INVALID;
  assign stat.recv_final = (imb_pkg::LEN_W'(rx_idx) + imb_pkg::LEN_W'(1)) == rx_len;

  always_ff @(posedge clk) begin
    if (rst) begin
      hub_core     <= '0;
      stg_count    <= '0;
      stg_overflow <= 1'b0;
      stg_ptr      <= imb_pkg::PTR_W'(imb_pkg::CORES);
      strobe       <= 1'b0;
      for (int i = 0; i < imb_pkg::CORES; i++) begin
        slot_full[i] <= 1'b0;
        buf_ptr[i]   <= imb_pkg::PTR_W'(i);
      end
    end else begin
      if (cfg_valid) begin
        hub_core <= cfg_data;
      end
      strobe <= cmd.post | cmd.recv_step | cmd.reply;
      if (cmd.stage) begin
        if (cmd.post) begin
          stg_count    <= '0;
          stg_overflow <= 1'b0;
        end else if (stg_room) begin
          stg_count <= stg_count + imb_pkg::LEN_W'(1);
        end else begin
          stg_overflow <= 1'b1;
        end
      end
      if (commit) begin
        slot_full[route_slot] <= 1'b1;
        buf_ptr[route_slot]   <= stg_ptr;
        stg_ptr               <= buf_ptr[route_slot];
      end
      if (cmd.recv_open) begin
        slot_full[req_slot] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.stage && stg_room) begin
      mem[wr_addr] <= data_byte;
    end
    if (commit) begin
      slot_src_core[route_slot]   <= post_src;
      slot_src_tid[route_slot]    <= src_tid;
      slot_final_dest[route_slot] <= post_fdest;
      slot_dest_tid[route_slot]   <= dst_thread;
      slot_length[route_slot]     <= post_len;
    end
    if (cmd.recv_open) begin
      rx_slot <= req_slot;
      rx_idx  <= '0;
      rx_len  <= slot_length[req_slot];
    end else if (cmd.recv_step) begin
      rx_idx <= rx_idx + imb_pkg::IDX_W'(1);
    end

    if (cmd.recv_step) begin
      status              <= imb_pkg::ST_OK;
      length              <= rx_len;
      out_src_core        <= slot_src_core[rx_slot];
      out_src_tid         <= slot_src_tid[rx_slot];
      out_final_dest_core <= slot_final_dest[rx_slot];
      out_dest_tid        <= slot_dest_tid[rx_slot];
      out_byte            <= mem[rd_addr];
      last                <= stat.recv_final;
      notify_valid        <= 1'b0;
      notify_core         <= '0;
    end else begin
      out_src_core        <= '0;
      out_src_tid         <= '0;
      out_final_dest_core <= '0;
      out_dest_tid        <= '0;
      out_byte            <= '0;
      last                <= 1'b1;
      if (cmd.post) begin
        status       <= post_status;
        length       <= commit ? post_len : '0;
        notify_valid <= commit;
        notify_core  <= commit ? imb_pkg::NOTIFY_W'(target_core) : '0;
      end else begin
        status       <= cmd.reply_code;
        length       <= '0;
        notify_valid <= 1'b0;
        notify_core  <= '0;
      end
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    notify_valid |-> strobe && (status == imb_pkg::ST_OK) && (length != '0))
    else $error("Notify raised without a successful post result.");

  assert property (@(posedge clk) disable iff (rst)
    strobe && !last |=> strobe && (length == $past(length)))
    else $error("Receive stream broke before its final word.");

  assert property (@(posedge clk) disable iff (rst)
    strobe && (status != imb_pkg::ST_OK) |-> last && (length == '0) && !notify_valid)
    else $error("Failed result is not a single zero-length word.");

  assert property (@(posedge clk) disable iff (rst)
    cmd.recv_open |=> !slot_full[rx_slot])
    else $error("Slot still full after its receive began.");

endmodule

// File: src/inter_core_mailbox.sv
// ----------------------------------------------------------------------------
// Inter-core mailbox
// One single-message slot per core with staged posting and streamed receive.
// ----------------------------------------------------------------------------
// A send or forward takes one payload word per cycle while busy is low; the
// word marked last yields one result word on the cycle after it is accepted,
// and the next item may be accepted in that same cycle. Committing a message
// swaps buffer pointers, so no payload is copied. A receive of an N-byte
// message holds busy while its bytes stream out; its slot, index and length
// are registered first, then its N result words follow one per cycle via the
// result registers, paced by the payload memory's single read port. Results
// are shown for one cycle under strobe and never stall. Config is always ready.
// ----------------------------------------------------------------------------
module inter_core_mailbox (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  output logic                            busy,
  input  logic [imb_pkg::OP_W-1:0]        op,
  input  logic [imb_pkg::REQ_W-1:0]       requester_core,
  input  logic [imb_pkg::CORE_W-1:0]      target_core,
  input  logic [imb_pkg::CORE_W-1:0]      end_core,
  input  logic [imb_pkg::TID_W-1:0]       dst_thread,
  input  logic [imb_pkg::CORE_W-1:0]      origin_core,
  input  logic [imb_pkg::TID_W-1:0]       src_tid,
  input  logic [imb_pkg::BYTE_W-1:0]      data_byte,
  input  logic                            byte_last,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [imb_pkg::HUB_W-1:0]       cfg_data,
  output logic                            strobe,
  output logic [imb_pkg::STATUS_W-1:0]    status,
  output logic [imb_pkg::LEN_W-1:0]       length,
  output logic [imb_pkg::CORE_W-1:0]      out_src_core,
  output logic [imb_pkg::TID_W-1:0]       out_src_tid,
  output logic [imb_pkg::CORE_W-1:0]      out_final_dest_core,
  output logic [imb_pkg::TID_W-1:0]       out_dest_tid,
  output logic [imb_pkg::BYTE_W-1:0]      out_byte,
  output logic                            last,
  output logic                            notify_valid,
  output logic [imb_pkg::NOTIFY_W-1:0]    notify_core
);

  imb_pkg::imb_cmd_t  cmd;
  imb_pkg::imb_stat_t stat;

  assign cfg_ready = 1'b1;

  imb_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .op        (op),
    .byte_last (byte_last),
    .stat      (stat),
    .busy      (busy),
    .cmd       (cmd)
  );

  imb_dp u_dp (
    .clk                 (clk),
    .rst                 (rst),
    .cmd                 (cmd),
    .op                  (op),
    .requester_core      (requester_core),
    .target_core         (target_core),
    .end_core            (end_core),
    .dst_thread          (dst_thread),
    .origin_core         (origin_core),
    .src_tid             (src_tid),
    .data_byte           (data_byte),
    .cfg_valid           (cfg_valid & cfg_ready),
    .cfg_data            (cfg_data),
    .stat                (stat),
    .strobe              (strobe),
    .status              (status),
    .length              (length),
    .out_src_core        (out_src_core),
    .out_src_tid         (out_src_tid),
    .out_final_dest_core (out_final_dest_core),
    .out_dest_tid        (out_dest_tid),
    .out_byte            (out_byte),
    .last                (last),
    .notify_valid        (notify_valid),
    .notify_core         (notify_core)
  );

endmodule
